// ----- design/first_fit_segment_allocator_macros.svh -----
// Assertion macros shared by the first-fit segment allocator modules.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define FFSA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define FFSA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ffsa_pkg.sv -----
// Package for the first-fit segment allocator: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
package ffsa_pkg;

    localparam int ALLOC_SLOTS = 16;
    localparam int FREE_SLOTS  = 17;
    localparam int ADDR_BITS   = 16;
    localparam int RESET_TOTAL = 1024;

    localparam int FIDX_W = $clog2(FREE_SLOTS);
    localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
    localparam int AIDX_W = $clog2(ALLOC_SLOTS);
    localparam int ACNT_W = $clog2(ALLOC_SLOTS + 1);
    localparam int IDX_W  = (FCNT_W > ACNT_W) ? FCNT_W : ACNT_W;
    localparam int DIFF_W = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;

    typedef logic [ADDR_BITS-1:0] addr_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_NO_PID = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    clr_idx;
        logic    inc_idx;
        logic    set_code;
        status_t code;
        logic    carve;
        logic    remove;
        logic    give;
        logic    emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_op;
        logic free_end;
        logic fit;
        logic alloc_full;
        logic alloc_end;
        logic pid_match;
        logic pos_stop;
    } sts_t;

endpackage

// ----- design/ffsa_datapath.sv -----
// Datapath of the first-fit segment allocator: free and allocation tables,
// scan index, request and result registers. Depends on ffsa_pkg and the macros header.
`include "first_fit_segment_allocator_macros.svh"

module ffsa_datapath import ffsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_op,
    input  logic [7:0]  in_pid,
    input  logic [15:0] in_size,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [1:0]  out_status,
    output logic [15:0] out_start,
    output logic [15:0] out_end
);

    addr_t               fs_start_reg [FREE_SLOTS];
    addr_t               fs_end_reg   [FREE_SLOTS];
    logic [FCNT_W-1:0]   fcnt_reg;
    logic [7:0]          a_owner_reg  [ALLOC_SLOTS];
    addr_t               a_start_reg  [ALLOC_SLOTS];
    addr_t               a_end_reg    [ALLOC_SLOTS];
    logic [ACNT_W-1:0]   acnt_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                op_reg;
    logic [7:0]          pid_reg;
    logic [15:0]         size_reg;
    status_t             code_reg;
    addr_t               rs_reg;
    addr_t               re_reg;
    logic [1:0]          ostat_reg;
    logic [15:0]         ostart_reg;
    logic [15:0]         oend_reg;

    logic [FIDX_W-1:0]   fidx;
    logic [AIDX_W-1:0]   aidx;
    logic [ADDR_BITS:0]  diff;
    addr_t               carve_end;
    logic                left;
    logic                right;

    assign fidx = idx_reg[FIDX_W-1:0];
    assign aidx = idx_reg[AIDX_W-1:0];

    // Fit test on the free segment under the scan index.
    always_comb begin
        diff      = {1'b0, fs_end_reg[fidx]} - {1'b0, fs_start_reg[fidx]};
        carve_end = fs_start_reg[fidx] + ADDR_BITS'(size_reg);
        sts.req_op     = op_reg;
        sts.free_end   = (FCNT_W'(idx_reg) >= fcnt_reg);
        sts.fit        = (size_reg != 16'd0) &&
                         (DIFF_W'(diff) >= DIFF_W'(size_reg));
        sts.alloc_full = (acnt_reg >= ACNT_W'(ALLOC_SLOTS));
        sts.alloc_end  = (ACNT_W'(idx_reg) >= acnt_reg);
        sts.pid_match  = (a_owner_reg[aidx] == pid_reg);
        sts.pos_stop   = sts.free_end || (fs_start_reg[fidx] >= rs_reg);
    end

    // Neighbor checks for returning a region at the found position.
    always_comb begin
        left  = (idx_reg != '0) && (fs_end_reg[fidx - FIDX_W'(1)] == rs_reg);
        right = !sts.free_end && (fs_start_reg[fidx] == re_reg);
    end

    // Free segment table.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            fs_start_reg[0] <= '0;
            fs_end_reg[0]   <= aresetn ? ADDR_BITS'(cfg_data) : ADDR_BITS'(RESET_TOTAL);
            if (aresetn) begin
                fcnt_reg <= (ADDR_BITS'(cfg_data) != '0) ? FCNT_W'(1) : '0;
            end else begin
                fcnt_reg <= (ADDR_BITS'(RESET_TOTAL) != '0) ? FCNT_W'(1) : '0;
            end
        end else if (cmd.carve) begin
            fs_start_reg[fidx] <= carve_end;
            if (carve_end == fs_end_reg[fidx]) begin
                for (int i = 0; i < FREE_SLOTS - 1; i++) begin
                    if (i >= int'(idx_reg) && i + 1 < int'(fcnt_reg)) begin
                        fs_start_reg[i] <= fs_start_reg[i+1];
                        fs_end_reg[i]   <= fs_end_reg[i+1];
                    end
                end
                fcnt_reg <= fcnt_reg - FCNT_W'(1);
            end
        end else if (cmd.give) begin
            priority if (left && right) begin
                fs_end_reg[fidx - FIDX_W'(1)] <= fs_end_reg[fidx];
                for (int i = 0; i < FREE_SLOTS - 1; i++) begin
                    if (i >= int'(idx_reg) && i + 1 < int'(fcnt_reg)) begin
                        fs_start_reg[i] <= fs_start_reg[i+1];
                        fs_end_reg[i]   <= fs_end_reg[i+1];
                    end
                end
                fcnt_reg <= fcnt_reg - FCNT_W'(1);
            end else if (left) begin
                fs_end_reg[fidx - FIDX_W'(1)] <= re_reg;
            end else if (right) begin
                fs_start_reg[fidx] <= rs_reg;
            end else if (fcnt_reg < FCNT_W'(FREE_SLOTS)) begin
                for (int i = 1; i < FREE_SLOTS; i++) begin
                    if (i > int'(idx_reg) && i <= int'(fcnt_reg)) begin
                        fs_start_reg[i] <= fs_start_reg[i-1];
                        fs_end_reg[i]   <= fs_end_reg[i-1];
                    end
                end
                fs_start_reg[fidx] <= rs_reg;
                fs_end_reg[fidx]   <= re_reg;
                fcnt_reg <= fcnt_reg + FCNT_W'(1);
            end else begin
                fcnt_reg <= fcnt_reg;
            end
        end
    end

    // Allocation table; entries below the count are valid, oldest first.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            acnt_reg <= '0;
        end else if (cmd.carve && !sts.alloc_full) begin
            a_owner_reg[acnt_reg[AIDX_W-1:0]] <= pid_reg;
            a_start_reg[acnt_reg[AIDX_W-1:0]] <= fs_start_reg[fidx];
            a_end_reg[acnt_reg[AIDX_W-1:0]]   <= carve_end;
            acnt_reg <= acnt_reg + ACNT_W'(1);
        end else if (cmd.remove) begin
            for (int i = 0; i < ALLOC_SLOTS - 1; i++) begin
                if (i >= int'(idx_reg)) begin
                    a_owner_reg[i] <= a_owner_reg[i+1];
                    a_start_reg[i] <= a_start_reg[i+1];
                    a_end_reg[i]   <= a_end_reg[i+1];
                end
            end
            acnt_reg <= acnt_reg - ACNT_W'(1);
        end
    end

    // Scan index.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_idx) begin
            idx_reg <= '0;
        end else if (cmd.inc_idx) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Request, working result and output registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            pid_reg  <= in_pid;
            size_reg <= in_size;
            rs_reg   <= '0;
            re_reg   <= '0;
        end else if (cmd.carve) begin
            rs_reg <= fs_start_reg[fidx];
            re_reg <= carve_end;
        end else if (cmd.remove) begin
            rs_reg <= a_start_reg[aidx];
            re_reg <= a_end_reg[aidx];
        end
        if (cmd.set_code) begin
            code_reg <= cmd.code;
        end
        if (cmd.emit) begin
            ostat_reg  <= code_reg;
            ostart_reg <= (code_reg == ST_OK) ? 16'(rs_reg) : 16'd0;
            oend_reg   <= (code_reg == ST_OK) ? 16'(re_reg) : 16'd0;
        end
    end

    assign out_status = ostat_reg;
    assign out_start  = ostart_reg;
    assign out_end    = oend_reg;

    `FFSA_ASSERT_ALWAYS(a_fcnt_bound, fcnt_reg <= FCNT_W'(FREE_SLOTS), "free count overflow")
    `FFSA_ASSERT_ALWAYS(a_acnt_bound, acnt_reg <= ACNT_W'(ALLOC_SLOTS), "alloc count overflow")
    `FFSA_ASSERT_IMPL(a_remove_valid, cmd.remove, !sts.alloc_end && sts.pid_match, "bad remove")
    `FFSA_ASSERT_NEXT(a_remove_dec, cmd.remove && !cfg_we, acnt_reg == $past(acnt_reg) - 1'b1,
        "remove did not shrink table")

endmodule

// ----- design/ffsa_ctrl.sv -----
// Controller of the first-fit segment allocator: sequences the table scans
// and the result handshake. Depends on ffsa_pkg.
module ffsa_ctrl import ffsa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_ASCAN, S_FSCAN, S_GSCAN, S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        cmd.code    = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load    = 1'b1;
                    cmd.clr_idx = 1'b1;
                    state_next  = S_ASCAN;
                end
            end
            S_ASCAN: begin
                if (sts.req_op == OP_FREE) begin
                    state_next = S_FSCAN;
                end else if (sts.free_end) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NO_FIT;
                    state_next   = S_RESP;
                end else if (sts.fit) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = sts.alloc_full ? ST_FULL : ST_OK;
                    cmd.carve    = !sts.alloc_full;
                    state_next   = S_RESP;
                end else begin
                    cmd.inc_idx = 1'b1;
                end
            end
            S_FSCAN: begin
                if (sts.alloc_end) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NO_PID;
                    state_next   = S_RESP;
                end else if (sts.pid_match) begin
                    cmd.set_code = 1'b1;
                    cmd.remove   = 1'b1;
                    cmd.clr_idx  = 1'b1;
                    state_next   = S_GSCAN;
                end else begin
                    cmd.inc_idx = 1'b1;
                end
            end
            S_GSCAN: begin
                if (sts.pos_stop) begin
                    cmd.give   = 1'b1;
                    state_next = S_RESP;
                end else begin
                    cmd.inc_idx = 1'b1;
                end
            end
            S_RESP: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.emit    = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ----- design/first_fit_segment_allocator.sv -----
// First-fit segment allocator over [0, total_size). Each request word is
// handled alone: the controller scans the free table (allocate) or the
// allocation table then the free table (free) one entry per clock. An
// allocate scans at most 17 free entries. A free scans at most 16 allocation
// entries and 17 free positions. A result that is not taken stalls the next
// result. The result sits in an output register until taken. Writing
// total_size clears all allocations; there is no clearing pass after reset.
module first_fit_segment_allocator import ffsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,   // total_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // pid [7:0], size [23:8]
    input  logic        s_tuser,    // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // region_start [15:0], region_end [31:16]
    output logic [1:0]  m_tuser     // status
);

    cmd_t cmd;
    sts_t sts;
    logic [15:0] rstart;
    logic [15:0] rend;

    assign cfg_ready = 1'b1;

    ffsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffsa_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .in_op      (s_tuser),
        .in_pid     (s_tdata[7:0]),
        .in_size    (s_tdata[23:8]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (m_tuser),
        .out_start  (rstart),
        .out_end    (rend)
    );

    assign m_tdata = {rend, rstart};

endmodule
